// ===== sv/nls_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nls_pkg
// Types, constants and codes shared by the note list sequencer modules.
// ----------------------------------------------------------------------------
package nls_pkg;

  localparam int NOTE_DEPTH_DEF = 256;
  localparam int FREQ_DEPTH     = 128;
  localparam int FREQ_IDX_W     = $clog2(FREQ_DEPTH);
  localparam int NOTE_WORD_W    = 40;
  localparam int CFG_IDX_W      = 1;
  localparam int CFG_DATA_W     = 8;

  localparam logic [31:0] END_MARK        = 32'hFFFF_FFFF;
  localparam logic [7:0]  HELD_MAX        = 8'hFF;
  localparam logic [7:0]  VOL_RESET       = 8'h77;
  localparam logic [7:0]  MAX_TICKS_RESET = 8'd150;

  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_VOLUME = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_NOTE_TICKS = 1'b1;

  typedef enum logic [1:0] {
    MODE_NOTE  = 2'd0,
    MODE_FREQ  = 2'd1,
    MODE_START = 2'd2,
    MODE_TICK  = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHK_ON,
    ST_CHORD_RD,
    ST_CHORD,
    ST_KEY_ON,
    ST_HELD,
    ST_WALK_RD,
    ST_WALK,
    ST_FINISH
  } state_t;

  typedef enum logic {
    RD_CUR,
    RD_NEXT
  } rd_sel_t;

  typedef struct packed {
    logic    accept;
    logic    note_we;
    logic    freq_we;
    logic    start;
    rd_sel_t rd_sel;
    logic    chord_start;
    logic    chord_adv;
    logic    key_on;
    logic    held_upd;
    logic    walk_adv;
    logic    walk_end;
    logic    out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic due;
    logic chord_max;
    logic walk_go;
    logic active;
  } dp_stat_t;

endpackage

// ===== sv/nls_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nls_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module nls_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/nls_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nls_ctrl
// Controller: runs both handshakes and sequences each tick word during playback
// through the chord skip when a note is due, the length counter and catch-up walk.
// ----------------------------------------------------------------------------
module nls_ctrl
  import nls_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_mode,
  output logic       out_valid,
  input  logic       out_stall,
  input  dp_stat_t   stat,
  output ctl_cmd_t   cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   in_acc;
  mode_t  mode;

  assign mode     = mode_t'(in_mode);
  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.rd_sel = RD_CUR;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_FINISH;
          unique case (mode)
            MODE_NOTE:  cmd.note_we = 1'b1;
            MODE_FREQ:  cmd.freq_we = 1'b1;
            MODE_START: cmd.start   = 1'b1;
            MODE_TICK: begin
              if (stat.active) begin
                state_nxt = ST_CHK_ON;
              end
            end
            default: state_nxt = ST_FINISH;
          endcase
        end
      end
      ST_CHK_ON: begin
        if (stat.due) begin
          cmd.chord_start = 1'b1;
          state_nxt       = ST_CHORD_RD;
        end else begin
          state_nxt = ST_HELD;
        end
      end
      ST_CHORD_RD: begin
        if (stat.chord_max) begin
          state_nxt = ST_KEY_ON;
        end else begin
          cmd.rd_sel = RD_NEXT;
          state_nxt  = ST_CHORD;
        end
      end
      ST_CHORD: begin
        if (stat.due) begin
          cmd.chord_adv = 1'b1;
          state_nxt     = ST_CHORD_RD;
        end else begin
          state_nxt = ST_KEY_ON;
        end
      end
      ST_KEY_ON: begin
        cmd.key_on = 1'b1;
        state_nxt  = ST_HELD;
      end
      ST_HELD: begin
        cmd.held_upd = 1'b1;
        state_nxt    = ST_WALK;
      end
      ST_WALK_RD: begin
        state_nxt = ST_WALK;
      end
      ST_WALK: begin
        if (stat.walk_go) begin
          cmd.walk_adv = 1'b1;
          state_nxt    = ST_WALK_RD;
        end else begin
          cmd.walk_end = 1'b1;
          state_nxt    = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!(out_valid_r && out_stall)) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == ST_CHK_ON || state_r == ST_FINISH))
    else $error("accepted word did not start processing");

  a_finish_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH && !(out_valid_r && out_stall))
      |=> (out_valid_r && state_r == ST_IDLE))
    else $error("finished result not presented");

  a_chord_read_order: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CHORD_RD |=> (state_r == ST_CHORD || state_r == ST_KEY_ON))
    else $error("chord skip left its loop unexpectedly");

  a_walk_read_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_HELD || state_r == ST_WALK_RD) |=> state_r == ST_WALK)
    else $error("catch-up walk check without a fresh read");

endmodule

// ===== sv/nls_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nls_datapath
// Datapath: note list and frequency table memories, playback counters,
// configuration registers and the result register.
// ----------------------------------------------------------------------------
module nls_datapath
  import nls_pkg::*;
#(
  parameter int NOTE_DEPTH = NOTE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [7:0]            in_slot,
  input  logic [31:0]           in_event_tick,
  input  logic                  in_is_note_on,
  input  logic [6:0]            in_note_number,
  input  logic [15:0]           in_freq_word,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  ctl_cmd_t              cmd,
  output dp_stat_t              stat,
  output logic                  out_key_on,
  output logic                  out_key_off,
  output logic [15:0]           out_freq_out,
  output logic [7:0]            out_volume_out,
  output logic                  out_playing
);

  localparam int IDX_W  = $clog2(NOTE_DEPTH);
  localparam int STEP_W = $clog2(NOTE_DEPTH + 1);

  typedef logic [IDX_W-1:0] slot_map_t [256];

  function automatic slot_map_t build_slot_map();
    slot_map_t m;
    int        c;
    c = 0;
    for (int i = 0; i < 256; i++) begin
      m[i] = IDX_W'(c);
      c = (c == NOTE_DEPTH - 1) ? 0 : c + 1;
    end
    return m;
  endfunction

  localparam slot_map_t SLOT_MAP = build_slot_map();

  logic [IDX_W-1:0]       cursor_r, cursor_next, note_raddr;
  logic [31:0]            now_r;
  logic [7:0]             held_r, held_inc;
  logic                   active_r;
  logic [STEP_W-1:0]      steps_r;
  logic [6:0]             pitch_r;
  logic                   kon_r, koff_r;
  logic [15:0]            fout_r;
  logic [7:0]             vout_r;
  logic [7:0]             vol_r, max_r;
  logic                   o_kon_r, o_koff_r, o_play_r;
  logic [15:0]            o_freq_r;
  logic [7:0]             o_vol_r;
  logic [NOTE_WORD_W-1:0] note_wdata, note_rdata;
  logic [15:0]            freq_rdata;
  logic [31:0]            rd_time;
  logic                   rd_flag;
  logic [6:0]             rd_pitch;

  assign cursor_next = (cursor_r == IDX_W'(NOTE_DEPTH - 1)) ? '0 : cursor_r + 1'b1;
  assign note_raddr  = (cmd.rd_sel == RD_NEXT) ? cursor_next : cursor_r;
  assign note_wdata  = {in_event_tick, in_is_note_on, in_note_number};

  nls_ram #(.WIDTH(NOTE_WORD_W), .DEPTH(NOTE_DEPTH)) u_note_ram (
    .clk   (clk),
    .we    (cmd.note_we),
    .waddr (SLOT_MAP[in_slot]),
    .wdata (note_wdata),
    .raddr (note_raddr),
    .rdata (note_rdata)
  );

  nls_ram #(.WIDTH(16), .DEPTH(FREQ_DEPTH)) u_freq_ram (
    .clk   (clk),
    .we    (cmd.freq_we),
    .waddr (in_note_number[FREQ_IDX_W-1:0]),
    .wdata (in_freq_word),
    .raddr (pitch_r[FREQ_IDX_W-1:0]),
    .rdata (freq_rdata)
  );

  assign rd_time  = note_rdata[39:8];
  assign rd_flag  = note_rdata[7];
  assign rd_pitch = note_rdata[6:0];
  assign held_inc = (held_r == HELD_MAX) ? held_r : held_r + 8'd1;

  assign stat.due       = (rd_time == now_r) && rd_flag;
  assign stat.chord_max = (steps_r == STEP_W'(NOTE_DEPTH - 1));
  assign stat.walk_go   = (steps_r < STEP_W'(NOTE_DEPTH)) && (rd_time <= now_r) &&
                          (rd_time != END_MARK);
  assign stat.active    = active_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r <= '0;
      now_r    <= '0;
      held_r   <= '0;
      active_r <= 1'b0;
      steps_r  <= '0;
      vol_r    <= VOL_RESET;
      max_r    <= MAX_TICKS_RESET;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_CHANNEL_VOLUME: vol_r <= cfg_data;
          REG_MAX_NOTE_TICKS: max_r <= cfg_data;
          default: vol_r <= vol_r;
        endcase
      end
      if (cmd.start) begin
        cursor_r <= '0;
        now_r    <= '0;
        active_r <= 1'b1;
      end
      if (cmd.chord_start) begin
        steps_r <= '0;
      end
      if (cmd.chord_adv || cmd.walk_adv) begin
        cursor_r <= cursor_next;
        steps_r  <= steps_r + 1'b1;
      end
      if (cmd.key_on) begin
        held_r <= '0;
      end
      if (cmd.held_upd) begin
        held_r  <= held_inc;
        steps_r <= '0;
      end
      if (cmd.walk_end) begin
        now_r <= now_r + 32'd1;
        if (rd_time == END_MARK) begin
          active_r <= 1'b0;
          cursor_r <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kon_r  <= 1'b0;
      koff_r <= 1'b0;
      fout_r <= '0;
      vout_r <= '0;
    end
    if (cmd.chord_start || cmd.chord_adv) begin
      pitch_r <= rd_pitch;
    end
    if (cmd.key_on) begin
      kon_r  <= 1'b1;
      fout_r <= freq_rdata;
      vout_r <= vol_r;
    end
    if (cmd.held_upd) begin
      koff_r <= (held_inc > max_r);
    end
    if (cmd.walk_end && (rd_time == END_MARK)) begin
      koff_r <= 1'b1;
    end
    if (cmd.out_load) begin
      o_kon_r  <= kon_r;
      o_koff_r <= koff_r;
      o_freq_r <= fout_r;
      o_vol_r  <= vout_r;
      o_play_r <= active_r;
    end
  end

  assign out_key_on     = o_kon_r;
  assign out_key_off    = o_koff_r;
  assign out_freq_out   = o_freq_r;
  assign out_volume_out = o_vol_r;
  assign out_playing    = o_play_r;

  a_steps_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    steps_r <= STEP_W'(NOTE_DEPTH))
    else $error("step counter beyond note list depth");

endmodule

// ===== sv/note_list_sequencer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// note_list_sequencer_core
// Single-track note sequencer: note list, frequency table and playback.
// ----------------------------------------------------------------------------
// Input words (in_valid / in_stall) carry a mode: load a note slot, load a
// frequency entry, start playback, or advance by one tick. Every word yields
// exactly one result word on the out_ channel (out_valid / out_stall).
// Configuration writes on cfg_we / cfg_index / cfg_data set the volume byte
// and the note length limit; they take effect at once.
// Load, start and idle tick words go straight to the finish state, which loads
// the result register. A tick word while playing first checks for a due note
// and, if there is one, skips ahead through the chord notes due at this tick and
// keys the last of them on; it then updates the length counter and walks the
// cursor past notes already due. Each note list step is a registered read of
// the note memory followed by a compare. One word is processed at a time; the
// next is accepted once the result is registered, even while that result still
// waits to be taken.
// A stalled result holds its output register, and a following finished
// result waits in the controller until the output register frees up.
// Reset clears the counters, the cursor and playback, and restores the
// register defaults; the memories keep whatever they held.
// ----------------------------------------------------------------------------
module note_list_sequencer_core
  import nls_pkg::*;
#(
  parameter int NOTE_DEPTH = NOTE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_mode,
  input  logic [7:0]            in_slot,
  input  logic [31:0]           in_event_tick,
  input  logic                  in_is_note_on,
  input  logic [6:0]            in_note_number,
  input  logic [15:0]           in_freq_word,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_key_on,
  output logic                  out_key_off,
  output logic [15:0]           out_freq_out,
  output logic [7:0]            out_volume_out,
  output logic                  out_playing,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  nls_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_mode   (in_mode),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  nls_datapath #(.NOTE_DEPTH(NOTE_DEPTH)) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_slot        (in_slot),
    .in_event_tick  (in_event_tick),
    .in_is_note_on  (in_is_note_on),
    .in_note_number (in_note_number),
    .in_freq_word   (in_freq_word),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .cmd            (cmd),
    .stat           (stat),
    .out_key_on     (out_key_on),
    .out_key_off    (out_key_off),
    .out_freq_out   (out_freq_out),
    .out_volume_out (out_volume_out),
    .out_playing    (out_playing)
  );

endmodule
